// File: hdl/assert_macros.svh
// Assertion macros used by the checker file rvc_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk_i, disabled while rst_ni is low.
`define RVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same, checked during reset as well.
`define RVC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/rvc_pkg.sv
// ----------------------------------------------------------------------------
// rvc_pkg
// Types and opcode constants shared by the RV32I step core.
// ----------------------------------------------------------------------------
`default_nettype none

package rvc_pkg;

  typedef struct packed {
    logic        func;
    logic [15:0] load_addr;
    logic [31:0] load_data;
  } in_req_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        still_running;
    logic        reg_written;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
  } out_rsp_t;

  // Byte memory access
  typedef struct packed {
    logic        en;
    logic        we;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [3:0]  bmask;   // bytes 0..3 of the word to write
  } mem_req_t;

  // Outcome of the execute stage
  typedef struct packed {
    logic        wr;
    logic [4:0]  rd;
    logic [31:0] val;
    logic [31:0] npc;
    logic        halt;
    logic        is_load;
    logic [2:0]  f3;
    logic        is_store;
    logic [31:0] mem_addr;
    logic [3:0]  bmask;
  } exec_t;

  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_B  = 3'd0;
  localparam logic [2:0] F3_H  = 3'd1;
  localparam logic [2:0] F3_W  = 3'd2;
  localparam logic [2:0] F3_BU = 3'd4;
  localparam logic [2:0] F3_HU = 3'd5;

endpackage

`default_nettype wire

// File: hdl/rvc_mem.sv
// ----------------------------------------------------------------------------
// rvc_mem
// Byte memory as four byte-lane banks; one word access per cycle, any
// alignment, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rvc_mem import rvc_pkg::*; #(
  parameter int MEM_BYTES = 65536
) (
  input  wire logic        clk_i,
  input  wire mem_req_t    req_i,
  output logic [31:0]      rdata_o
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int RW = AW - 2;
  localparam int ROWS = MEM_BYTES / 4;

  logic [AW-1:0]   a;
  logic [1:0]      sel_q;
  logic [3:0][7:0] lanes;

  assign a = req_i.addr[AW-1:0];

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0]    mem [ROWS];
    logic [7:0]    lane_q;
    logic [1:0]    off;
    logic [AW-1:0] b;
    logic [RW-1:0] row;
    logic          we;
    logic [7:0]    wbyte;

    assign off   = 2'(k) - a[1:0];
    assign b     = a + AW'(off);
    assign row   = b[AW-1:2];
    assign we    = req_i.we & req_i.bmask[off];
    assign wbyte = req_i.wdata[8*off +: 8];

    always_ff @(posedge clk_i) begin
      if (req_i.en) begin
        if (we) begin
          mem[row] <= wbyte;
        end else if (!req_i.we) begin
          lane_q <= mem[row];
        end
      end
    end

    assign lanes[k] = lane_q;
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en && !req_i.we) begin
      sel_q <= a[1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rdata_o[8*i +: 8] = lanes[2'(sel_q + 2'(i))];
    end
  end

endmodule

`default_nettype wire

// File: hdl/rvc_regs.sv
// ----------------------------------------------------------------------------
// rvc_regs
// 32x32 register file, two registered read ports, one write port.
// Valid bits give the reset contents without a clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rvc_regs #(
  parameter int MEM_BYTES = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        re_i,
  input  wire logic [4:0]  ra1_i,
  input  wire logic [4:0]  ra2_i,
  input  wire logic        we_i,
  input  wire logic [4:0]  wa_i,
  input  wire logic [31:0] wd_i,
  output logic [31:0]      rd1_o,
  output logic [31:0]      rd2_o
);

  localparam logic [4:0]  SP_IDX = 5'd2;
  localparam logic [31:0] SP_RST = 32'(MEM_BYTES - 1);

  logic [31:0] mem [32];
  logic [31:0] vld_q;
  logic [31:0] d1_q, d2_q;
  logic [4:0]  a1_q, a2_q;
  logic        v1_q, v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[wa_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
    if (re_i) begin
      d1_q <= mem[ra1_i];
      d2_q <= mem[ra2_i];
      a1_q <= ra1_i;
      a2_q <= ra2_i;
      v1_q <= vld_q[ra1_i];
      v2_q <= vld_q[ra2_i];
    end
  end

  assign rd1_o = v1_q ? d1_q : ((a1_q == SP_IDX) ? SP_RST : '0);
  assign rd2_o = v2_q ? d2_q : ((a2_q == SP_IDX) ? SP_RST : '0);

endmodule

`default_nettype wire

// File: hdl/rvc_exec.sv
// ----------------------------------------------------------------------------
// rvc_exec
// Decode and execute of one RV32I instruction word.
// ----------------------------------------------------------------------------
`default_nettype none

module rvc_exec import rvc_pkg::*; (
  input  wire logic [31:0] instr_i,
  input  wire logic [31:0] pc_i,
  input  wire logic [31:0] rs1_i,
  input  wire logic [31:0] rs2_i,
  output exec_t            ex_o
);

  logic [6:0]  opc, f7;
  logic [2:0]  f3;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
  logic [31:0] opb, pc4;
  logic [4:0]  sh;
  logic        is_op, take;

  assign opc   = instr_i[6:0];
  assign f3    = instr_i[14:12];
  assign f7    = instr_i[31:25];
  assign imm_i = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_b = {{19{instr_i[31]}}, instr_i[31], instr_i[7], instr_i[30:25],
                  instr_i[11:8], 1'b0};
  assign imm_j = {{11{instr_i[31]}}, instr_i[31], instr_i[19:12], instr_i[20],
                  instr_i[30:21], 1'b0};
  assign imm_u = {instr_i[31:12], 12'b0};
  assign is_op = (opc == OPC_OP);
  assign opb   = is_op ? rs2_i : imm_i;
  assign sh    = opb[4:0];
  assign pc4   = pc_i + 32'd4;

  always_comb begin
    case (f3)
      F3_BEQ:  take = (rs1_i == rs2_i);
      F3_BNE:  take = (rs1_i != rs2_i);
      F3_BLT:  take = ($signed(rs1_i) < $signed(rs2_i));
      F3_BGE:  take = !($signed(rs1_i) < $signed(rs2_i));
      F3_BLTU: take = (rs1_i < rs2_i);
      F3_BGEU: take = (rs1_i >= rs2_i);
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    ex_o          = '0;
    ex_o.rd       = instr_i[11:7];
    ex_o.npc      = pc4;
    ex_o.f3       = f3;
    case (opc)
      OPC_OP, OPC_OP_IMM: begin
        ex_o.wr = 1'b1;
        case (f3)
          F3_ADD: begin
            if (!is_op || f7 == F7_BASE) begin
              ex_o.val = rs1_i + opb;
            end else if (f7 == F7_ALT) begin
              ex_o.val = rs1_i - opb;
            end else begin
              ex_o.wr = 1'b0;
            end
          end
          F3_SLL:  ex_o.val = rs1_i << sh;
          F3_SLT:  ex_o.val = {31'b0, $signed(rs1_i) < $signed(opb)};
          F3_SLTU: ex_o.val = {31'b0, rs1_i < opb};
          F3_XOR:  ex_o.val = rs1_i ^ opb;
          F3_SR: begin
            if (f7 == F7_BASE) begin
              ex_o.val = rs1_i >> sh;
            end else if (f7 == F7_ALT) begin
              ex_o.val = 32'($signed(rs1_i) >>> sh);
            end else begin
              ex_o.wr = 1'b0;
            end
          end
          F3_OR:   ex_o.val = rs1_i | opb;
          F3_AND:  ex_o.val = rs1_i & opb;
          default: ex_o.wr = 1'b0;
        endcase
      end
      OPC_BRANCH: begin
        if (take) begin
          ex_o.npc = pc_i + imm_b;
        end
      end
      OPC_STORE: begin
        ex_o.mem_addr = rs1_i + imm_s;
        case (f3)
          F3_B:    ex_o.bmask = 4'b0001;
          F3_H:    ex_o.bmask = 4'b0011;
          F3_W:    ex_o.bmask = 4'b1111;
          default: ex_o.bmask = 4'b0000;
        endcase
        ex_o.is_store = (ex_o.bmask != 4'b0000);
      end
      OPC_LOAD: begin
        ex_o.is_load  = 1'b1;
        ex_o.mem_addr = rs1_i + imm_i;
      end
      OPC_SYSTEM: begin
        if (f3 == F3_ADD && f7 == F7_BASE) begin
          ex_o.halt = 1'b1;
          ex_o.npc  = pc_i;
        end
      end
      OPC_LUI: begin
        ex_o.wr  = 1'b1;
        ex_o.val = imm_u;
      end
      OPC_AUIPC: begin
        ex_o.wr  = 1'b1;
        ex_o.val = pc_i + imm_u;
      end
      OPC_JAL: begin
        ex_o.wr  = 1'b1;
        ex_o.val = pc4;
        ex_o.npc = pc_i + imm_j;
      end
      OPC_JALR: begin
        ex_o.wr  = 1'b1;
        ex_o.val = pc4;
        ex_o.npc = (rs1_i + imm_i) & ~32'd1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/rv32i_core_step_core.sv
// ----------------------------------------------------------------------------
// rv32i_core_step_core
// Single-issue RV32I core that runs one instruction per request.
// ----------------------------------------------------------------------------
// A request with func 1 stores load_data little-endian at load_addr and
// answers in the cycle after acceptance; a request with func 0 runs one
// instruction: fetch from the byte memory, register file read, execute and
// write back, and for a load a second access to the single memory port. A
// func 0 request on a halted core answers in the cycle after acceptance.
// The next request is taken once the core is idle and the output register
// is empty or its result is taken in that cycle. Memory is four byte-lane
// banks, so words of any alignment take one access; addresses wrap at
// MEM_BYTES, which must be a power of two. Memory contents are undefined
// until written. The user must write end_address through the cfg port
// only while the core is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32i_core_step_core import rvc_pkg::*; #(
  parameter int MEM_BYTES = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_req_t     in_req_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_rsp_t         out_rsp_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_LOAD  = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] pc_q, pc_d;
  logic        run_q, run_d;
  logic [15:0] end_q;
  logic [31:0] instr_q;
  exec_t       ld_q;          // pending load: rd, funct3, next pc
  out_rsp_t    out_q, out_d;
  logic        out_vld_q, out_vld_d;

  mem_req_t    mreq;
  logic [31:0] mrdata;
  exec_t       ex;
  logic [31:0] rs1, rs2;
  logic        rf_re, rf_we;

  // Retire path
  logic        fin;
  logic        fin_wr;
  logic [4:0]  fin_rd;
  logic [31:0] fin_val, fin_npc;
  logic        fin_halt;
  logic        ld_ok;
  logic [31:0] ld_val;

  logic accept;

  // Output register frees in the cycle it is taken
  assign in_ready_o  = (state_q == ST_IDLE) && (!out_vld_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  rvc_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
    .clk_i  (clk_i),
    .req_i  (mreq),
    .rdata_o(mrdata)
  );

  // Register file read comes straight from the fetched word
  assign rf_re = (state_q == ST_FETCH);

  rvc_regs #(.MEM_BYTES(MEM_BYTES)) u_regs (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .re_i  (rf_re),
    .ra1_i (mrdata[19:15]),
    .ra2_i (mrdata[24:20]),
    .we_i  (rf_we),
    .wa_i  (fin_rd),
    .wd_i  (fin_val),
    .rd1_o (rs1),
    .rd2_o (rs2)
  );

  rvc_exec u_exec (
    .instr_i(instr_q),
    .pc_i   (pc_q),
    .rs1_i  (rs1),
    .rs2_i  (rs2),
    .ex_o   (ex)
  );

  // Load data extraction
  always_comb begin
    ld_ok = 1'b1;
    case (ld_q.f3)
      F3_B:    ld_val = {{24{mrdata[7]}}, mrdata[7:0]};
      F3_H:    ld_val = {{16{mrdata[15]}}, mrdata[15:0]};
      F3_W:    ld_val = mrdata;
      F3_BU:   ld_val = {24'b0, mrdata[7:0]};
      F3_HU:   ld_val = {16'b0, mrdata[15:0]};
      default: begin
        ld_val = '0;
        ld_ok  = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    mreq      = '0;
    fin       = 1'b0;
    fin_wr    = 1'b0;
    fin_rd    = ex.rd;
    fin_val   = ex.val;
    fin_npc   = ex.npc;
    fin_halt  = ex.halt;
    out_d     = out_q;
    out_vld_d = out_vld_q && !out_ready_i;
    pc_d      = pc_q;
    run_d     = run_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_i.func) begin
            // Preload: one write, immediate answer
            mreq.en    = 1'b1;
            mreq.we    = 1'b1;
            mreq.addr  = {16'b0, in_req_i.load_addr};
            mreq.wdata = in_req_i.load_data;
            mreq.bmask = 4'b1111;
            out_d      = '{next_pc: pc_q, still_running: run_q, default: '0};
            out_vld_d  = 1'b1;
          end else if (run_q) begin
            mreq.en   = 1'b1;
            mreq.addr = pc_q;
            state_d   = ST_FETCH;
          end else begin
            out_d     = '{next_pc: pc_q, still_running: 1'b0, default: '0};
            out_vld_d = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (ex.is_load) begin
          mreq.en   = 1'b1;
          mreq.addr = ex.mem_addr;
          state_d   = ST_LOAD;
        end else begin
          if (ex.is_store) begin
            mreq.en    = 1'b1;
            mreq.we    = 1'b1;
            mreq.addr  = ex.mem_addr;
            mreq.wdata = rs2;
            mreq.bmask = ex.bmask;
          end
          fin     = 1'b1;
          fin_wr  = ex.wr;
          state_d = ST_IDLE;
        end
      end
      ST_LOAD: begin
        fin      = 1'b1;
        fin_wr   = ld_ok;
        fin_rd   = ld_q.rd;
        fin_val  = ld_val;
        fin_npc  = ld_q.npc;
        fin_halt = 1'b0;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    // Write back: x0 writes are dropped and reported as no write
    rf_we = fin && fin_wr && (fin_rd != 5'd0);
    if (fin) begin
      pc_d  = fin_npc;
      run_d = !fin_halt && !((end_q != 16'd0) && (fin_npc > {16'b0, end_q}));
      out_d = '{next_pc:       fin_npc,
                still_running: run_d,
                reg_written:   rf_we,
                dest_index:    rf_we ? fin_rd : 5'd0,
                dest_value:    rf_we ? fin_val : 32'd0};
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pc_q      <= '0;
      run_q     <= 1'b1;
      end_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pc_q      <= pc_d;
      run_q     <= run_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        end_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (state_q == ST_FETCH) begin
      instr_q <= mrdata;
    end
    if (state_q == ST_EXEC) begin
      ld_q <= ex;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rvc_checker.sv
// ----------------------------------------------------------------------------
// rvc_checker
// Port-level checks for the RV32I step core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rvc_checker import rvc_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire out_rsp_t out_rsp_o
);

  logic halted_q;

  // A halted core stays halted until reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q <= 1'b0;
    end else if (out_valid_o && out_ready_i && !out_rsp_o.still_running) begin
      halted_q <= 1'b1;
    end
  end

  `RVC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")
  `RVC_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_rsp_o), "result changed")
  `RVC_ASSERT(a_no_x0, out_valid_o && out_rsp_o.reg_written |-> out_rsp_o.dest_index != 5'd0, "x0 write reported")
  `RVC_ASSERT(a_halt_sticky, out_valid_o && halted_q |-> !out_rsp_o.still_running, "core restarted")

endmodule

bind rv32i_core_step_core rvc_checker u_rvc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_rsp_o  (out_rsp_o)
);

`default_nettype wire
